FILE: rtl/stq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted expiry timer queue - shared types and constants
// Field widths, command and status codes, and the cell control word that
// the queue controller hands to every cell of the sorted chain.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int CAPACITY     = 64;
	localparam int ID_W         = 16;
	localparam int TIME_W       = 32;
	localparam int IDLE_W       = 16;
	localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd5;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_ADJUST = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_TICK   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_DUP     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_POP
	} cell_op_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_REINSERT,
		FSM_TICK
	} state_t;

	// One timer slot as seen by the neighbouring cells
	typedef struct packed {
		logic              vld;
		logic [TIME_W-1:0] exp;
		logic [ID_W-1:0]   hdl;
	} slot_t;

	// Broadcast control word for the cell chain
	typedef struct packed {
		cell_op_t          op;
		logic [ID_W-1:0]   key_id;
		logic [TIME_W-1:0] key_exp;
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/stq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted expiry timer queue - one cell of the sorted chain
// Holds one timer slot. Flags whether it lies after the insert point and
// whether it holds the searched handle, and moves data to or from its
// neighbours as the broadcast command says.
// ----------------------------------------------------------------------------
module stq_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire stq_pkg::cell_ctl_t ctl,
	input  wire stq_pkg::slot_t   left_slot,
	input  wire                   left_gt,
	input  wire                   left_after,
	input  wire stq_pkg::slot_t   right_slot,
	output stq_pkg::slot_t        slot,
	output logic                  gt,
	output logic                  match,
	output logic                  after
);
	import stq_pkg::*;

	slot_t slot_q;
	slot_t slot_d;

	// Local compares: later than the key, or empty; holds the searched handle
	assign gt    = !slot_q.vld || (slot_q.exp > ctl.key_exp);
	assign match = slot_q.vld && (slot_q.hdl == ctl.key_id);
	assign after = match || left_after;
	assign slot  = slot_q;

	// Choose what this cell holds next
	always_comb begin
		slot_d = slot_q;
		unique case (ctl.op)
			CELL_INSERT: begin
				if (left_gt) begin
					slot_d = left_slot;
				end else if (gt) begin
					slot_d.vld = 1'b1;
					slot_d.exp = ctl.key_exp;
					slot_d.hdl = ctl.key_id;
				end
			end
			CELL_REMOVE: begin
				if (after) begin
					slot_d = right_slot;
				end
			end
			CELL_POP: slot_d = right_slot;
			CELL_HOLD: slot_d = slot_q;
			default: slot_d = slot_q;
		endcase
	end

	// Slot register: occupancy flag and timer payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sorted_expiry_timer_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted expiry timer queue - top level
// A chain of CAPACITY cells keeps timers sorted by ascending expiry.
//
// Input words arrive on s_*: tuser carries the command (add, adjust,
// delete, tick), tdata the handle, the expiry and the current time.
// Result words leave on m_*: one per add, adjust or delete carrying the
// status; one per expired timer for a tick (at least one), with tlast and
// the wait until the next expiry (else idle_timeout) on the final word.
// An adjust whose handle is found makes a remove pass, then an insert pass,
// through the chain; a tick pops one head per cycle while the output
// register is free. A new word is taken once the previous one has issued
// its final result into the output register.
// Reset empties the chain at once and sets idle_timeout to 5.
// When the receiver holds m_tready low the result word is held and the chain
// stops, but for an adjust's remove pass, until the output register is free.
// cfg_we writes idle_timeout; write only while the queue is idle.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_queue (
	input  wire         clk,
	input  wire         arst_n,
	// idle_timeout register
	input  wire         cfg_we,
	input  wire  [15:0] cfg_wdata,
	// command words
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [1:0]  s_tuser,   // action
	input  wire  [79:0] s_tdata,   // entry_id, expire_time, now_time
	// result words
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [0:0]  m_tuser,   // expired_valid
	output logic [55:0] m_tdata,   // expired_id, wait_seconds, status, zero pad
	output logic        m_tlast
);
	import stq_pkg::*;

	// Command registers
	state_t            state_q, state_d;
	action_t           cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] exp_q;
	logic [TIME_W-1:0] now_q;
	logic [IDLE_W-1:0] idle_q;

	// Output register
	logic              ob_vld_q;
	logic              ob_xv_q;
	logic [ID_W-1:0]   ob_id_q;
	logic [TIME_W-1:0] ob_wait_q;
	status_t           ob_st_q;
	logic              ob_last_q;

	logic              ob_load;
	logic              ob_xv_d;
	logic [ID_W-1:0]   ob_id_d;
	logic [TIME_W-1:0] ob_wait_d;
	status_t           ob_st_d;
	logic              ob_last_d;
	logic              ob_free;

	// Chain signals
	cell_ctl_t         ctl;
	cell_op_t          op_d;
	slot_t             cell_slot [CAPACITY];
	logic              cell_gt    [CAPACITY];
	logic              cell_match [CAPACITY];
	logic              cell_after [CAPACITY];
	logic [CAPACITY-1:0] match_vec;
	logic              any_match;
	logic              full;
	logic              head_exp;
	logic              next_exp;
	logic [TIME_W-1:0] idle_wide;

	assign ctl.op      = op_d;
	assign ctl.key_id  = id_q;
	assign ctl.key_exp = exp_q;

	// Cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		slot_t lslot, rslot;
		logic  lgt, lafter;
		if (i == 0) begin : g_first
			assign lslot  = '0;
			assign lgt    = 1'b0;
			assign lafter = 1'b0;
		end else begin : g_mid
			assign lslot  = cell_slot[i-1];
			assign lgt    = cell_gt[i-1];
			assign lafter = cell_after[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rslot = '0;
		end else begin : g_inner
			assign rslot = cell_slot[i+1];
		end
		stq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left_slot  (lslot),
			.left_gt    (lgt),
			.left_after (lafter),
			.right_slot (rslot),
			.slot       (cell_slot[i]),
			.gt         (cell_gt[i]),
			.match      (cell_match[i]),
			.after      (cell_after[i])
		);
		assign match_vec[i] = cell_match[i];
	end

	// Chain status seen by the controller
	assign any_match = |match_vec;
	assign full      = cell_slot[CAPACITY-1].vld;
	assign head_exp  = cell_slot[0].vld && (cell_slot[0].exp <= now_q);
	assign next_exp  = cell_slot[1].vld && (cell_slot[1].exp <= now_q);
	assign idle_wide = {{(TIME_W-IDLE_W){1'b0}}, idle_q};
	assign ob_free   = !ob_vld_q || m_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (s_tvalid) begin
					state_d = (action_t'(s_tuser) == ACT_TICK) ? FSM_TICK : FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if ((cmd_q == ACT_ADJUST) && any_match) begin
					state_d = FSM_REINSERT;
				end else if (ob_free) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_REINSERT: begin
				if (ob_free) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_TICK: begin
				if (ob_free && !(head_exp && next_exp)) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// Chain command and result word
	always_comb begin
		s_tready  = (state_q == FSM_IDLE);
		op_d      = CELL_HOLD;
		ob_load   = 1'b0;
		ob_xv_d   = 1'b0;
		ob_id_d   = '0;
		ob_wait_d = '0;
		ob_st_d   = ST_OK;
		ob_last_d = 1'b1;
		unique case (state_q)
			FSM_IDLE: begin
				op_d = CELL_HOLD;
			end
			FSM_EXEC: begin
				priority if (cmd_q == ACT_ADD) begin
					if (ob_free) begin
						ob_load = 1'b1;
						if (any_match) begin
							ob_st_d = ST_DUP;
						end else if (full) begin
							ob_st_d = ST_FULL;
						end else begin
							op_d = CELL_INSERT;
						end
					end
				end else if (!any_match) begin
					if (ob_free) begin
						ob_load = 1'b1;
						ob_st_d = ST_UNKNOWN;
					end
				end else if (cmd_q == ACT_ADJUST) begin
					op_d = CELL_REMOVE;
				end else begin
					if (ob_free) begin
						ob_load = 1'b1;
						op_d    = CELL_REMOVE;
					end
				end
			end
			FSM_REINSERT: begin
				if (ob_free) begin
					ob_load = 1'b1;
					op_d    = CELL_INSERT;
				end
			end
			FSM_TICK: begin
				if (ob_free) begin
					ob_load = 1'b1;
					if (head_exp) begin
						op_d      = CELL_POP;
						ob_xv_d   = 1'b1;
						ob_id_d   = cell_slot[0].hdl;
						ob_last_d = !next_exp;
						if (!next_exp) begin
							ob_wait_d = cell_slot[1].vld ? (cell_slot[1].exp - now_q)
							                             : idle_wide;
						end
					end else begin
						ob_wait_d = cell_slot[0].vld ? (cell_slot[0].exp - now_q)
						                             : idle_wide;
					end
				end
			end
			default: op_d = CELL_HOLD;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			idle_q   <= IDLE_RESET;
			ob_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				idle_q <= cfg_wdata;
			end
			if (ob_load) begin
				ob_vld_q <= 1'b1;
			end else if (m_tready) begin
				ob_vld_q <= 1'b0;
			end
		end
	end

	// Latch the command word on accept
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= action_t'(s_tuser);
			id_q  <= s_tdata[15:0];
			exp_q <= s_tdata[47:16];
			now_q <= s_tdata[79:48];
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ob_load) begin
			ob_xv_q   <= ob_xv_d;
			ob_id_q   <= ob_id_d;
			ob_wait_q <= ob_wait_d;
			ob_st_q   <= ob_st_d;
			ob_last_q <= ob_last_d;
		end
	end

	assign m_tvalid   = ob_vld_q;
	assign m_tuser[0] = ob_xv_q;
	assign m_tdata    = {6'd0, ob_st_q, ob_wait_q, ob_id_q};
	assign m_tlast    = ob_last_q;

endmodule
`default_nettype wire

FILE: rtl/stq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted expiry timer queue - port checker
// Watches the result channel for words whose fields contradict each other
// and for a held word that changes while stalled.
// ----------------------------------------------------------------------------
module stq_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [0:0]  m_tuser,
	input wire [55:0] m_tdata,
	input wire        m_tlast
);
	import stq_pkg::*;

	// Stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
		&& $stable(m_tuser))
		else $error("result word changed while stalled");

	// A word without an expired handle carries handle zero and ends its command
	a_noexp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[15:0] == '0) && m_tlast)
		else $error("non-expiry word with handle or without last");

	// Words before the last of a tick are expiries with no wait
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[0] && (m_tdata[47:16] == '0))
		else $error("intermediate word malformed");

	// Expiry words always report ok
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (status_t'(m_tdata[49:48]) == ST_OK)
		&& (m_tdata[55:50] == '0))
		else $error("expiry word with bad status");

endmodule

bind sorted_expiry_timer_queue stq_checker u_stq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

FILE: dv/tb_sorted_expiry_timer_queue.sv
// ----------------------------------------------------------------------------
// Sorted expiry timer queue - testbench
// Drives add, adjust, delete and tick commands into the queue. A scoreboard
// keeps its own sorted timer table and works out the result words of each
// accepted command. Each result word is checked field by field against the
// oldest outstanding prediction. Both stream sides idle at random. The idle
// timeout register is rewritten between phases, once the queue has drained.
// ----------------------------------------------------------------------------
module tb_sorted_expiry_timer_queue;
	import stq_pkg::*;

	typedef struct packed {
		logic              hit;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] wait_s;
		status_t           st;
		logic              lst;
	} timer_result_t;

	// Sorted timer table plus the queue of result words it predicts
	class timer_queue_scoreboard;
		logic [TIME_W-1:0] expiry [CAPACITY];
		logic [ID_W-1:0]   handle [CAPACITY];
		int                count;
		logic [IDLE_W-1:0] idle_to;
		timer_result_t     due_results [$];
		int                errors;

		function new();
			count   = 0;
			idle_to = IDLE_RESET;
			errors  = 0;
		endfunction

		function int locate(logic [ID_W-1:0] id);
			for (int i = 0; i < count; i++) begin
				if (handle[i] == id)
					return i;
			end
			return -1;
		endfunction

		// Close the gap left by the entry at pos
		function void take_out(int pos);
			for (int i = pos; i + 1 < count; i++) begin
				expiry[i] = expiry[i + 1];
				handle[i] = handle[i + 1];
			end
			count--;
		endfunction

		// Insert after every entry that expires no later than e
		function void place(logic [ID_W-1:0] id, logic [TIME_W-1:0] e);
			int pos;
			pos = 0;
			while (pos < count && expiry[pos] <= e)
				pos++;
			for (int i = count; i > pos; i--) begin
				expiry[i] = expiry[i - 1];
				handle[i] = handle[i - 1];
			end
			expiry[pos] = e;
			handle[pos] = id;
			count++;
		endfunction

		function void set_idle(logic [IDLE_W-1:0] v);
			idle_to = v;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void note_command(action_t act, logic [ID_W-1:0] id,
				logic [TIME_W-1:0] e, logic [TIME_W-1:0] now);
			int                pos;
			int                popped;
			logic [TIME_W-1:0] next_wait;
			timer_result_t     r;
			r.hit    = 1'b0;
			r.id     = '0;
			r.wait_s = '0;
			r.st     = ST_OK;
			r.lst    = 1'b1;
			case (act)
				ACT_ADD: begin
					if (locate(id) >= 0)
						r.st = ST_DUP;
					else if (count >= CAPACITY)
						r.st = ST_FULL;
					else
						place(id, e);
					due_results.push_back(r);
				end
				ACT_ADJUST, ACT_DELETE: begin
					pos = locate(id);
					if (pos < 0) begin
						r.st = ST_UNKNOWN;
					end else begin
						take_out(pos);
						if (act == ACT_ADJUST)
							place(id, e);
					end
					due_results.push_back(r);
				end
				default: begin
					// Tick: pop every head that is due, equal time included
					popped = 0;
					while (popped < count && expiry[popped] <= now)
						popped++;
					next_wait = (popped < count) ? expiry[popped] - now
						: {{(TIME_W-IDLE_W){1'b0}}, idle_to};
					if (popped == 0) begin
						r.wait_s = next_wait;
						due_results.push_back(r);
					end
					for (int k = 0; k < popped; k++) begin
						r.hit    = 1'b1;
						r.id     = handle[k];
						r.lst    = (k == popped - 1);
						r.wait_s = r.lst ? next_wait : '0;
						due_results.push_back(r);
					end
					for (int k = 0; k + popped < count; k++) begin
						expiry[k] = expiry[k + popped];
						handle[k] = handle[k + popped];
					end
					count -= popped;
				end
			endcase
		endfunction

		function void compare_field(string field, logic [TIME_W-1:0] want,
				logic [TIME_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic hit, logic [ID_W-1:0] id,
				logic [TIME_W-1:0] wait_s, logic [1:0] st, logic lst);
			timer_result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: result word with nothing expected, expected none, actual id %0h",
					$time, id);
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare_field("expired_valid", TIME_W'(want.hit), TIME_W'(hit));
			compare_field("expired_id", TIME_W'(want.id), TIME_W'(id));
			compare_field("wait_seconds", want.wait_s, wait_s);
			compare_field("status", TIME_W'(want.st), TIME_W'(st));
			compare_field("last", TIME_W'(want.lst), TIME_W'(lst));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;   // action
	logic [79:0] s_tdata;   // entry_id, expire_time, now_time
	logic        m_tvalid;
	logic        m_tready;
	logic [0:0]  m_tuser;   // expired_valid
	logic [55:0] m_tdata;   // expired_id, wait_seconds, status, zero pad
	logic        m_tlast;

	timer_queue_scoreboard sb = new();
	bit                    no_idle;
	logic [TIME_W-1:0]     now_t;
	logic [ID_W-1:0]       pool_base;

	sorted_expiry_timer_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: stall at random except during the steady stretch
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = no_idle || ($urandom_range(0, 99) >= 27);
		end
	end

	// Check every result word taken by the receiver
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser[0], m_tdata[15:0], m_tdata[47:16],
				m_tdata[49:48], m_tlast);
	end

	// Present one command word, with an optional gap first; return at a falling edge
	task send_cmd(action_t act, logic [ID_W-1:0] id, logic [TIME_W-1:0] e,
			logic [TIME_W-1:0] now);
		while (!no_idle && $urandom_range(0, 99) < 27) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = act;
		s_tdata  = {now, e, id};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_command(act, id, e, now);
		@(negedge clk);
	endtask

	// Hold off until every predicted word has arrived and the queue settles
	task wait_for_results();
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(negedge clk);
	endtask

	task write_idle(logic [IDLE_W-1:0] v);
		wait_for_results();
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we    = 1'b0;
		sb.set_idle(v);
	endtask

	function logic [ID_W-1:0] pool_id();
		if ($urandom_range(0, 99) < 10)
			return ID_W'($urandom);
		return pool_base ^ ID_W'($urandom_range(0, 95));
	endfunction

	// Mostly a handle that is in the table, so adjust and delete find it
	function logic [ID_W-1:0] known_id();
		if (sb.count > 0 && $urandom_range(0, 99) < 80)
			return sb.handle[$urandom_range(0, sb.count - 1)];
		return pool_id();
	endfunction

	function logic [TIME_W-1:0] near_exp();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return $urandom;
		if (r < 8)
			return '0;
		if (r < 11)
			return '1;
		return now_t + $urandom_range(0, 40);
	endfunction

	task run_mixed(int n_items);
		int r;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				send_cmd(ACT_ADD, pool_id(), near_exp(), $urandom);
			end else if (r < 50) begin
				send_cmd(ACT_ADJUST, known_id(), near_exp(), $urandom);
			end else if (r < 62) begin
				send_cmd(ACT_DELETE, known_id(), $urandom, $urandom);
			end else if (r < 87) begin
				// Advance time, now and then far enough to drain the table
				now_t += $urandom_range(0, 12);
				if ($urandom_range(0, 99) < 6)
					now_t += $urandom_range(100, 3000);
				send_cmd(ACT_TICK, ID_W'($urandom), $urandom, now_t);
			end else begin
				send_cmd(action_t'($urandom_range(0, 3)), ID_W'($urandom), $urandom,
					$urandom);
			end
		end
	endtask

	// Fill past capacity, then drain everything in one tick
	task fill_table();
		pool_base = ID_W'($urandom);
		for (int k = 0; k < 72; k++)
			send_cmd(ACT_ADD, pool_base ^ ID_W'(k), near_exp(), $urandom);
		send_cmd(ACT_TICK, ID_W'($urandom), $urandom, '1);
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tuser   = ACT_ADD;
		s_tdata   = '0;
		no_idle   = 1'b0;
		now_t     = $urandom_range(0, 1 << 20);
		pool_base = ID_W'($urandom);
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset timeout, extremes, equal expiries, error codes
		send_cmd(ACT_TICK, 16'h0000, 32'h0, 32'h0);
		send_cmd(ACT_ADD, 16'h0000, 32'h0, $urandom);
		send_cmd(ACT_ADD, 16'hFFFF, 32'hFFFF_FFFF, $urandom);
		send_cmd(ACT_ADD, 16'h0000, 32'd7, $urandom);
		send_cmd(ACT_ADD, 16'h1234, 32'd100, $urandom);
		send_cmd(ACT_ADD, 16'h1235, 32'd100, $urandom);
		send_cmd(ACT_ADJUST, 16'h7777, 32'd3, $urandom);
		send_cmd(ACT_DELETE, 16'h7777, $urandom, $urandom);
		send_cmd(ACT_ADJUST, 16'h1235, 32'd50, $urandom);
		send_cmd(ACT_ADJUST, 16'h0000, 32'd100, $urandom);
		send_cmd(ACT_TICK, ID_W'($urandom), $urandom, 32'd49);
		send_cmd(ACT_TICK, ID_W'($urandom), $urandom, 32'd50);
		send_cmd(ACT_DELETE, 16'h1234, $urandom, $urandom);
		send_cmd(ACT_ADD, 16'h5555, 32'd100, $urandom);
		send_cmd(ACT_TICK, ID_W'($urandom), $urandom, 32'd100);
		send_cmd(ACT_TICK, ID_W'($urandom), $urandom, 32'hFFFF_FFFF);
		send_cmd(ACT_ADD, 16'hAAAA, 32'hFFFF_FFFF, $urandom);
		send_cmd(ACT_ADD, 16'h5A5A, 32'h0, $urandom);
		send_cmd(ACT_TICK, ID_W'($urandom), $urandom, 32'hFFFF_FFFF);
		send_cmd(ACT_DELETE, 16'hAAAA, $urandom, $urandom);
		send_cmd(ACT_TICK, ID_W'($urandom), $urandom, 32'h0);

		// Random phases under several timeout settings
		write_idle(16'h0000);
		send_cmd(ACT_TICK, ID_W'($urandom), $urandom, 32'hFFFF_FFFF);
		run_mixed(100);
		fill_table();

		write_idle(16'hFFFF);
		send_cmd(ACT_TICK, ID_W'($urandom), $urandom, 32'hFFFF_FFFF);
		no_idle = 1'b1;
		run_mixed(75);
		wait_for_results();
		run_mixed(75);
		no_idle = 1'b0;

		write_idle(IDLE_W'($urandom));
		run_mixed(40);
		fill_table();

		// Drain, then allow for the queue's own latency
		wait_for_results();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_expiry_timer_queue.sv
rtl/stq_checker.sv
dv/tb_sorted_expiry_timer_queue.sv
